@@ hdl/fdl_pkg.sv @@
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared constants, register map and configuration type of the fractional
// feedback delay.
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

    // buffer depth must be a power of two: read positions wrap by bit width
    localparam int BUFFER_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FRAC_W       = 16;
    localparam int POS_W        = ADDR_W + FRAC_W;
    // signed delay sum: wide enough for the smoothed delay plus swing, and
    // for the largest clamped delay with a sign bit
    localparam int DLY_W        = (POS_W + 1 > 34) ? POS_W + 1 : 34;

    localparam int AUDIO_W      = 24;
    localparam int MOD_W        = 16;

    localparam int NUM_REGS     = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W    = CFG_ADDR_W - 2;

    localparam logic [14:0]      FB_MAX           = 15'd31130;
    localparam logic [15:0]      WET_ONE          = 16'd32768;
    localparam logic [15:0]      SMOOTH_COEFF_RST = 16'd262;
    localparam logic [POS_W-1:0] MAX_DELAY        =
        POS_W'(BUFFER_DEPTH - 1) << FRAC_W;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DELAY_TARGET  = REG_IDX_W'(0),
        REG_MOD_DEPTH     = REG_IDX_W'(1),
        REG_FEEDBACK_GAIN = REG_IDX_W'(2),
        REG_WET_MIX       = REG_IDX_W'(3),
        REG_SMOOTH_COEFF  = REG_IDX_W'(4)
    } t_reg_idx;

    typedef struct packed {
        logic [23:0] delay_target;
        logic [15:0] mod_depth;
        logic [14:0] feedback_gain;
        logic [15:0] wet_mix;
        logic [15:0] smooth_coeff;
    } t_cfg;

endpackage

`default_nettype wire

@@ hdl/fdl_if.sv @@
// ----------------------------------------------------------------------------
// fdl_if
// Valid/ready channels of the fractional feedback delay: input samples and
// output samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdl_in_if import fdl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [AUDIO_W-1:0] audio_in;
    logic signed [MOD_W-1:0]   mod_in;
    logic                      first_in_block;

    modport source (output valid, output audio_in, output mod_in,
                    output first_in_block, input ready);
    modport sink   (input valid, input audio_in, input mod_in,
                    input first_in_block, output ready);
endinterface

interface fdl_out_if import fdl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [AUDIO_W-1:0] audio_out;

    modport source (output valid, output audio_out, input ready);
    modport sink   (input valid, input audio_out, output ready);
endinterface

`default_nettype wire

@@ hdl/fractional_feedback_delay.sv @@
// ----------------------------------------------------------------------------
// fractional_feedback_delay
// Feedback delay line read at a smoothed, modulated fractional delay with
// linear interpolation, and a dry/wet mix at the output.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 65536-entry sample buffer to zero, one
// entry per clock, and input ready stays low until the sweep is done;
// register writes are taken during the sweep. One sample at a time passes a
// sequencer through the smoothing, modulation and feedback multiplies, the
// smoothing update (first sample of a block only), the delay clamp, the read
// address and registered buffer read (both taps on two read ports), the
// interpolation multiply and add, the mix multiplies and the output load. The
// result sits in an output register, so the next sample is accepted while it
// waits to be taken; a stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_feedback_delay import fdl_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    fdl_in_if.sink                     i_in,
    fdl_out_if.source                  o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DLY,
        ST_ADDR,
        ST_INTERP,
        ST_SAMPLE,
        ST_MIX,
        ST_OUT
    } t_state;

    function automatic logic signed [AUDIO_W-1:0] sat24(input logic signed [26:0] x);
        logic signed [26:0] hi;
        logic signed [26:0] lo;
        hi = 27'sd8388607;
        lo = -27'sd8388608;
        if (x > hi) begin
            sat24 = 24'sh7FFFFF;
        end else if (x < lo) begin
            sat24 = 24'sh800000;
        end else begin
            sat24 = x[AUDIO_W-1:0];
        end
    endfunction

    t_cfg cfg;

    t_state                     r_state;
    logic                       r_clearing;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic signed [AUDIO_W-1:0]  r_audio;
    logic signed [MOD_W-1:0]    r_mod;
    logic                       r_first;
    logic signed [49:0]         r_step_prod;
    logic signed [32:0]         r_mod_prod;
    logic signed [39:0]         r_fbk_prod;
    logic signed [AUDIO_W-1:0]  r_wr_data;
    logic [31:0]                r_smoothed;
    logic [POS_W-1:0]           r_delay;
    logic [FRAC_W-1:0]          r_frac;
    logic [ADDR_W-1:0]          r_wp;
    logic signed [41:0]         r_interp_prod;
    logic signed [AUDIO_W-1:0]  r_last;
    logic signed [AUDIO_W-1:0]  r_sample;
    logic signed [41:0]         r_mix;
    logic                       r_out_valid;
    logic signed [AUDIO_W-1:0]  r_out_data;

    logic [14:0]                fb_gain;
    logic [15:0]                wet;
    logic [15:0]                dry;
    logic signed [32:0]         diff;
    logic signed [49:0]         n_step_prod;
    logic signed [32:0]         n_mod_prod;
    logic signed [39:0]         n_fbk_prod;
    logic [31:0]                n_smoothed;
    logic signed [25:0]         wr_sum;
    logic signed [AUDIO_W-1:0]  n_wr_data;
    logic signed [DLY_W-1:0]    delay_sum;
    logic [POS_W-1:0]           n_delay;
    logic [POS_W-1:0]           rd_pos;
    logic [ADDR_W-1:0]          rd_idx1;
    logic [ADDR_W-1:0]          rd_idx0;
    logic signed [AUDIO_W-1:0]  y0;
    logic signed [AUDIO_W-1:0]  y1;
    logic signed [AUDIO_W:0]    dy;
    logic signed [41:0]         n_interp_prod;
    logic signed [25:0]         sample_sum;
    logic signed [AUDIO_W-1:0]  n_sample;
    logic signed [41:0]         n_mix;
    logic signed [AUDIO_W-1:0]  n_out_data;
    logic                       out_load;
    logic                       in_ready;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [AUDIO_W-1:0]         ram_wdata;
    logic                       ram_re;
    logic [AUDIO_W-1:0]         ram_rdata_a;
    logic [AUDIO_W-1:0]         ram_rdata_b;

    fdl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fdl_ram #(
        .DATA_W (AUDIO_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (rd_idx0),
        .i_raddr_b (rd_idx1),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign fb_gain = (cfg.feedback_gain > FB_MAX) ? FB_MAX : cfg.feedback_gain;
    assign wet     = (cfg.wet_mix > WET_ONE) ? WET_ONE : cfg.wet_mix;
    assign dry     = WET_ONE - wet;

    assign y0 = $signed(ram_rdata_a);
    assign y1 = $signed(ram_rdata_b);

    always_comb begin
        // smoothing step and the two other products of the first step
        diff        = $signed({1'b0, cfg.delay_target, 8'h00})
                    - $signed({1'b0, r_smoothed});
        n_step_prod = $signed({1'b0, cfg.smooth_coeff}) * diff;
        n_mod_prod  = r_mod * $signed({1'b0, cfg.mod_depth});
        n_fbk_prod  = r_last * $signed({1'b0, fb_gain});

        // smoothed delay wraps modulo 2^32
        n_smoothed  = r_smoothed + r_step_prod[47:16];
        wr_sum      = $signed({{2{r_audio[AUDIO_W-1]}}, r_audio})
                    + $signed({r_fbk_prod[39], r_fbk_prod[39:15]});
        n_wr_data   = sat24($signed({wr_sum[25], wr_sum}));

        delay_sum   = $signed({{(DLY_W-32){1'b0}}, r_smoothed})
                    + DLY_W'(r_mod_prod >>> 7);
        if (delay_sum < 0) begin
            n_delay = '0;
        end else if (delay_sum > $signed({{(DLY_W-POS_W){1'b0}}, MAX_DELAY})) begin
            n_delay = MAX_DELAY;
        end else begin
            n_delay = delay_sum[POS_W-1:0];
        end

        // position behind the write pointer wraps with the buffer
        rd_pos  = {r_wp, {FRAC_W{1'b0}}} - r_delay;
        rd_idx1 = rd_pos[POS_W-1:FRAC_W];
        rd_idx0 = rd_idx1 - ADDR_W'(1);

        dy            = $signed({y1[AUDIO_W-1], y1}) - $signed({y0[AUDIO_W-1], y0});
        n_interp_prod = dy * $signed({1'b0, r_frac});
        sample_sum    = $signed({{2{y0[AUDIO_W-1]}}, y0}) + r_interp_prod[41:16];
        n_sample      = sample_sum[AUDIO_W-1:0];

        n_mix       = r_audio * $signed({1'b0, dry}) + r_sample * $signed({1'b0, wet});
        n_out_data  = sat24(r_mix[41:15]);
    end

    assign in_ready = (r_state == ST_IDLE) && !r_clearing;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);
    assign ram_re   = (r_state == ST_ADDR);

    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            // write after both taps are read, so a zero delay sees the old entry
            ram_we    = (r_state == ST_INTERP);
            ram_waddr = r_wp;
            ram_wdata = r_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_last      <= '0;
            r_smoothed  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_out_data;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && in_ready) begin
                        r_audio <= i_in.audio_in;
                        r_mod   <= i_in.mod_in;
                        r_first <= i_in.first_in_block;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_step_prod <= n_step_prod;
                    r_mod_prod  <= n_mod_prod;
                    r_fbk_prod  <= n_fbk_prod;
                    r_state     <= ST_UPD;
                end
                ST_UPD: begin
                    if (r_first) begin
                        r_smoothed <= n_smoothed;
                    end
                    r_wr_data <= n_wr_data;
                    r_state   <= ST_DLY;
                end
                ST_DLY: begin
                    r_delay <= n_delay;
                    r_state <= ST_ADDR;
                end
                ST_ADDR: begin
                    r_frac  <= rd_pos[FRAC_W-1:0];
                    r_state <= ST_INTERP;
                end
                ST_INTERP: begin
                    r_interp_prod <= n_interp_prod;
                    r_wp          <= r_wp + ADDR_W'(1);
                    r_state       <= ST_SAMPLE;
                end
                ST_SAMPLE: begin
                    r_sample <= n_sample;
                    r_last   <= n_sample;
                    r_state  <= ST_MIX;
                end
                ST_MIX: begin
                    r_mix   <= n_mix;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.audio_out = r_out_data;

endmodule

`default_nettype wire

@@ hdl/fdl_ram.sv @@
// ----------------------------------------------------------------------------
// fdl_ram
// Generic synchronous RAM: one write port, two read ports, registered read
// data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [DATA_W-1:0] o_rdata_a,
    output logic      [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

@@ hdl/fdl_cfg.sv @@
// ----------------------------------------------------------------------------
// fdl_cfg
// APB-style register file: delay target, modulation depth, feedback gain,
// wet mix and smoothing coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_cfg import fdl_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_target  <= '0;
            r_cfg.mod_depth     <= '0;
            r_cfg.feedback_gain <= '0;
            r_cfg.wet_mix       <= '0;
            r_cfg.smooth_coeff  <= SMOOTH_COEFF_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DELAY_TARGET:  r_cfg.delay_target  <= pwdata[23:0];
                REG_MOD_DEPTH:     r_cfg.mod_depth     <= pwdata[15:0];
                REG_FEEDBACK_GAIN: r_cfg.feedback_gain <= pwdata[14:0];
                REG_WET_MIX:       r_cfg.wet_mix       <= pwdata[15:0];
                REG_SMOOTH_COEFF:  r_cfg.smooth_coeff  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DELAY_TARGET:  prdata = {8'h00, r_cfg.delay_target};
            REG_MOD_DEPTH:     prdata = {16'h0000, r_cfg.mod_depth};
            REG_FEEDBACK_GAIN: prdata = {17'h00000, r_cfg.feedback_gain};
            REG_WET_MIX:       prdata = {16'h0000, r_cfg.wet_mix};
            REG_SMOOTH_COEFF:  prdata = {16'h0000, r_cfg.smooth_coeff};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/fdl_checker.sv @@
// ----------------------------------------------------------------------------
// fdl_checker
// Port-level checks of the fractional feedback delay, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_checker import fdl_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic signed [AUDIO_W-1:0] i_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output data changed while stalled");

    // one sample in flight: no input transaction on the next cycle
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a sample is in flight");

    // reset starts the buffer sweep and empties the output register
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("ready or valid high right after reset");

endmodule

bind fractional_feedback_delay fdl_checker u_fdl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.audio_out)
);

`default_nettype wire

@@ verif/tb_fractional_feedback_delay.sv @@
// ----------------------------------------------------------------------------
// tb_fractional_feedback_delay
// Self-checking bench for the fractional feedback delay. A short table of
// directed samples comes first, then random host blocks under random register
// settings. Both channels stall at random but in two steady phases. Outputs are
// checked against a delay-line model or typed values, readback against a shadow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fractional_feedback_delay import fdl_pkg::*;;

    localparam int     IDLE_PCT       = 36;
    localparam int     RAND_PHASES    = 11;
    localparam int     PHASE_ITEMS    = 150;
    localparam int     DRAIN_CYCLES   = 20;
    localparam int     WATCHDOG_LIMIT = 200000;
    localparam int     DIR_ROWS       = 22;
    localparam longint SAT_HI         = 8388607;
    localparam longint SAT_LO         = -8388608;
    localparam longint MAX_DLY        = longint'(BUFFER_DEPTH - 1) << FRAC_W;
    localparam longint POS_SPAN       = longint'(BUFFER_DEPTH) << FRAC_W;

    localparam logic signed [AUDIO_W-1:0] AUD_MAX = 24'sh7FFFFF;
    localparam logic signed [AUDIO_W-1:0] AUD_MIN = 24'sh800000;
    localparam logic signed [MOD_W-1:0]   MOD_MAX = 16'sh7FFF;
    localparam logic signed [MOD_W-1:0]   MOD_MIN = 16'sh8000;

    typedef struct packed {
        bit                        reconf;
        logic [1:0]                cfg_sel;
        logic signed [AUDIO_W-1:0] audio;
        logic signed [MOD_W-1:0]   mod;
        logic                      first;
        bit                        typed;
        logic signed [AUDIO_W-1:0] out_typed;
    } t_stim_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    fdl_in_if  in_if ();
    fdl_out_if out_if ();

    fractional_feedback_delay dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // delay line model state and register shadow
    t_cfg                      cfg_shadow;
    logic signed [AUDIO_W-1:0] tap_mem [BUFFER_DEPTH];
    logic [ADDR_W-1:0]         tap_wr_ptr;
    logic signed [AUDIO_W-1:0] prev_tap;
    logic [31:0]               glide_delay;

    logic signed [AUDIO_W-1:0] audio_out_q [$];
    logic signed [AUDIO_W-1:0] out_want;
    int                        fail_count = 0;
    int                        quiet_cycles = 0;
    bit                        steady = 1'b0;
    t_stim_row                 dir_rows [DIR_ROWS];
    t_cfg                      dir_cfgs [4];

    function automatic longint sat24(longint x);
        if (x > SAT_HI) return SAT_HI;
        if (x < SAT_LO) return SAT_LO;
        return x;
    endfunction

    function automatic logic signed [AUDIO_W-1:0] delay_line_predict(
        logic signed [AUDIO_W-1:0] audio,
        logic signed [MOD_W-1:0]   mod,
        logic                      first
    );
        longint            a, diff, dly, pos, fr, y0, y1, tap, fb, fbk, wet, mix;
        logic [ADDR_W-1:0] i0, i1;
        a = audio;
        // one-pole glide toward the target, once per host block
        if (first) begin
            diff = (longint'(cfg_shadow.delay_target) <<< 8) - longint'(glide_delay);
            glide_delay = 32'(longint'(glide_delay)
                + ((longint'(cfg_shadow.smooth_coeff) * diff) >>> 16));
        end
        dly = longint'(glide_delay)
            + ((longint'(mod) * longint'(cfg_shadow.mod_depth)) >>> 7);
        if (dly < 0) dly = 0;
        if (dly > MAX_DLY) dly = MAX_DLY;
        pos = (longint'(tap_wr_ptr) <<< FRAC_W) - dly;
        if (pos < 0) pos = pos + POS_SPAN;
        fr = pos & ((longint'(1) << FRAC_W) - 1);
        i1 = ADDR_W'(pos >>> FRAC_W);
        i0 = i1 - ADDR_W'(1);
        y0 = tap_mem[i0];
        y1 = tap_mem[i1];
        tap = y0 + (((y1 - y0) * fr) >>> FRAC_W);
        fb = (cfg_shadow.feedback_gain > FB_MAX) ? FB_MAX : cfg_shadow.feedback_gain;
        fbk = (longint'(prev_tap) * fb) >>> 15;
        tap_mem[tap_wr_ptr] = AUDIO_W'(sat24(a + fbk));
        prev_tap = AUDIO_W'(tap);
        wet = (cfg_shadow.wet_mix > WET_ONE) ? WET_ONE : cfg_shadow.wet_mix;
        mix = a * (longint'(WET_ONE) - wet) + tap * wet;
        tap_wr_ptr = tap_wr_ptr + ADDR_W'(1);
        return AUDIO_W'(sat24(mix >>> 15));
    endfunction

    function automatic logic [CFG_ADDR_W-1:0] reg_addr(t_reg_idx idx);
        return {idx, 2'b00};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] cfg_field(t_cfg c, t_reg_idx idx);
        case (idx)
            REG_DELAY_TARGET:  return CFG_DATA_W'(c.delay_target);
            REG_MOD_DEPTH:     return CFG_DATA_W'(c.mod_depth);
            REG_FEEDBACK_GAIN: return CFG_DATA_W'(c.feedback_gain);
            REG_WET_MIX:       return CFG_DATA_W'(c.wet_mix);
            REG_SMOOTH_COEFF:  return CFG_DATA_W'(c.smooth_coeff);
            default:           return '0;
        endcase
    endfunction

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_registers();
        t_reg_idx              idx;
        logic [CFG_DATA_W-1:0] want;
        for (int i = 0; i < NUM_REGS; i++) begin
            idx     = t_reg_idx'(i);
            want    = cfg_field(cfg_shadow, idx);
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b0;
            paddr   = reg_addr(idx);
            @(negedge i_clk);
            penable = 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== want) begin
                $display("%0t: %s readback mismatch, expected %0d, actual %0d",
                         $time, idx.name(), want, prdata);
                fail_count++;
            end
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    task automatic apply_settings(t_cfg c);
        t_reg_idx idx;
        for (int i = 0; i < NUM_REGS; i++) begin
            idx = t_reg_idx'(i);
            apb_write(reg_addr(idx), cfg_field(c, idx));
        end
        // unmapped index, must leave every register alone
        apb_write({REG_IDX_W'($urandom_range(NUM_REGS, (1 << REG_IDX_W) - 1)), 2'b00},
                  $urandom);
        cfg_shadow = c;
        check_registers();
    endtask

    task automatic wait_idle();
        while (audio_out_q.size() != 0) @(negedge i_clk);
    endtask

    // called at a falling edge; valid stays high afterwards for back-to-back samples
    task automatic send_sample(
        logic signed [AUDIO_W-1:0] audio,
        logic signed [MOD_W-1:0]   mod,
        logic                      first,
        bit                        typed,
        logic signed [AUDIO_W-1:0] out_typed
    );
        logic signed [AUDIO_W-1:0] predicted;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          = 1'b1;
        in_if.audio_in       = audio;
        in_if.mod_in         = mod;
        in_if.first_in_block = first;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted = delay_line_predict(audio, mod, first);
        audio_out_q.push_back(typed ? out_typed : predicted);
        @(negedge i_clk);
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (audio_out_q.size() == 0) begin
                $display("%0t: audio_out transaction with nothing expected, actual %0d",
                         $time, out_if.audio_out);
                fail_count++;
            end else begin
                out_want = audio_out_q.pop_front();
                if (out_if.audio_out !== out_want) begin
                    $display("%0t: audio_out mismatch, expected %0d, actual %0d",
                             $time, out_want, out_if.audio_out);
                    fail_count++;
                end
            end
        end
    end

    // the clearing sweep after reset keeps input ready low until every buffer entry is cleared
    wire bus_busy = (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                  || (psel && penable);

    always @(posedge i_clk) begin
        if (bus_busy) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row                 row;
        t_cfg                      nxt;
        logic signed [AUDIO_W-1:0] audio;
        logic signed [MOD_W-1:0]   mod;
        logic                      first;
        int                        block_left;

        in_if.valid          = 1'b0;
        in_if.audio_in       = '0;
        in_if.mod_in         = '0;
        in_if.first_in_block = 1'b0;
        cfg_shadow  = '{24'd0, 16'd0, 15'd0, 16'd0, SMOOTH_COEFF_RST};
        tap_wr_ptr  = '0;
        prev_tap    = '0;
        glide_delay = '0;
        block_left  = 0;
        for (int i = 0; i < BUFFER_DEPTH; i++) tap_mem[i] = '0;

        dir_cfgs = '{
            // gains above their limits, negative delays clamp to zero
            '{24'd0,        16'd65535, 15'd32767, 16'd65535, 16'd65535},
            // longest target, positive swing clamps at the top
            '{24'd16776960, 16'd65535, FB_MAX,    WET_ONE,   16'd65535},
            // glide back down to 3.5 samples
            '{24'd896,      16'd0,     15'd16384, 16'd16384, 16'd65535},
            // 19.5 samples at write position 20: the taps straddle entries 65535 and 0
            '{24'd4992,     16'd0,     15'd0,     WET_ONE,   16'd65535}
        };
        dir_rows = '{
            // reset settings: dry only, output equals input
            '{1'b0, 2'd0, AUD_MAX,      MOD_MAX,     1'b1, 1'b1, AUD_MAX},
            '{1'b0, 2'd0, AUD_MIN,      MOD_MIN,     1'b0, 1'b1, AUD_MIN},
            '{1'b0, 2'd0, 24'sd0,       16'sd0,      1'b0, 1'b1, 24'sd0},
            '{1'b0, 2'd0, 24'sd1234567, 16'sd0,      1'b1, 1'b1, 24'sd1234567},
            '{1'b1, 2'd0, AUD_MAX,      MOD_MIN,     1'b1, 1'b0, 24'sd0},
            '{1'b0, 2'd0, AUD_MIN,      MOD_MIN,     1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd0, AUD_MAX,      16'sd0,      1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd0, AUD_MAX,      MOD_MAX,     1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd0, -24'sd1,      16'sd16384,  1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd0, 24'sd100000,  -16'sd1,     1'b1, 1'b0, 24'sd0},
            '{1'b1, 2'd1, AUD_MAX,      16'sd0,      1'b1, 1'b0, 24'sd0},
            '{1'b0, 2'd1, AUD_MIN,      MOD_MAX,     1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd1, 24'sd4096,    MOD_MIN,     1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd1, 24'sd0,       MOD_MAX,     1'b1, 1'b0, 24'sd0},
            '{1'b1, 2'd2, 24'sd2000000, 16'sd0,      1'b1, 1'b0, 24'sd0},
            '{1'b0, 2'd2, -24'sd3000000, 16'sd0,     1'b1, 1'b0, 24'sd0},
            '{1'b0, 2'd2, 24'sd5,       16'sd0,      1'b1, 1'b0, 24'sd0},
            '{1'b0, 2'd2, -24'sd5,      16'sd0,      1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd2, AUD_MAX,      16'sd0,      1'b0, 1'b0, 24'sd0},
            '{1'b0, 2'd2, AUD_MIN,      16'sd0,      1'b0, 1'b0, 24'sd0},
            '{1'b1, 2'd3, 24'sd777777,  16'sd0,      1'b1, 1'b0, 24'sd0},
            '{1'b0, 2'd3, -24'sd777777, 16'sd0,      1'b0, 1'b0, 24'sd0}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        check_registers();

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.reconf) begin
                in_if.valid = 1'b0;
                wait_idle();
                apply_settings(dir_cfgs[row.cfg_sel]);
            end
            send_sample(row.audio, row.mod, row.first, row.typed, row.out_typed);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            in_if.valid = 1'b0;
            wait_idle();
            steady = (ph == 4 || ph == 5);

            case ($urandom_range(0, 7))
                0:       nxt.delay_target = 24'($urandom_range(0, 16776960));
                1:       nxt.delay_target = '0;
                default: nxt.delay_target = 24'($urandom_range(0, 400 * 256));
            endcase
            case ($urandom_range(0, 7))
                0:       nxt.mod_depth = '0;
                1:       nxt.mod_depth = 16'hFFFF;
                2:       nxt.mod_depth = 16'($urandom);
                default: nxt.mod_depth = 16'($urandom_range(0, 4096));
            endcase
            nxt.feedback_gain = 15'($urandom);
            nxt.wet_mix = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 32768));
            case ($urandom_range(0, 7))
                0, 1:    nxt.smooth_coeff = 16'hFFFF;
                2:       nxt.smooth_coeff = '0;
                default: nxt.smooth_coeff = 16'($urandom);
            endcase
            apply_settings(nxt);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 15) == 0)
                    audio = $urandom_range(0, 1) ? AUD_MAX : AUD_MIN;
                else if ($urandom_range(0, 3) == 0)
                    audio = 24'($urandom_range(0, 4095)) - 24'sd2048;
                else
                    audio = 24'($urandom);
                case ($urandom_range(0, 7))
                    0:       mod = $urandom_range(0, 1) ? MOD_MAX : MOD_MIN;
                    1, 2:    mod = 16'($urandom_range(0, 64)) - 16'sd32;
                    default: mod = 16'($urandom);
                endcase
                // host blocks of random length, with a stray block flag now and then
                if (block_left == 0) begin
                    block_left = $urandom_range(1, 32);
                    first = 1'b1;
                end else begin
                    first = 1'b0;
                end
                block_left--;
                if ($urandom_range(0, 19) == 0) first = 1'($urandom_range(0, 1));
                send_sample(audio, mod, first, 1'b0, 24'sd0);
            end
        end

        in_if.valid = 1'b0;
        steady = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && audio_out_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
